// ===== rtl/smpq_pkg.sv =====
// ----------------------------------------------------------------------------
// smpq_pkg
// Shared types and constants of the stable min-first priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package smpq_pkg;

  localparam int unsigned CAPACITY       = 16;
  localparam int unsigned PAYLOAD_WIDTH  = 32;
  localparam int unsigned PRIORITY_WIDTH = 16;
  localparam int unsigned CNT_W          = $clog2(CAPACITY + 1);
  localparam int unsigned STATUS_W       = 2;

  typedef logic [PAYLOAD_WIDTH-1:0]  payload_t;
  typedef logic [PRIORITY_WIDTH-1:0] priority_t;
  typedef logic [CNT_W-1:0]          count_t;

  typedef enum logic [0:0] {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the input transfer
    logic exec;   // apply the operation and load the result register
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/smpq_if.sv =====
// ----------------------------------------------------------------------------
// smpq_in_if / smpq_out_if
// Valid/ready channels carrying queue operations and their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface smpq_in_if;
  import smpq_pkg::*;

  logic      valid;
  logic      ready;
  logic      kind;
  priority_t priority_req;
  payload_t  payload;

  modport source (output valid, kind, priority_req, payload, input ready);
  modport sink   (input valid, kind, priority_req, payload, output ready);
endinterface

interface smpq_out_if;
  import smpq_pkg::*;

  logic                valid;
  logic                ready;
  payload_t            out_payload;
  logic [STATUS_W-1:0] status;
  priority_t           head_priority;
  payload_t            head_payload;
  count_t              entry_count;

  modport source (output valid, out_payload, status, head_priority, head_payload,
                  entry_count, input ready);
  modport sink   (input valid, out_payload, status, head_priority, head_payload,
                  entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/smpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// smpq_ctrl
// Sequencer: takes one operation, runs it once the result register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output smpq_pkg::cmd_t     cmd_o
);
  import smpq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   exec;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    exec       = 1'b0;
    case (state_q)
      S_IDLE:  in_ready_o = 1'b1;
      S_EXEC:  exec = !out_valid_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        exec       = 1'b0;
      end
    endcase
  end

  always_comb begin
    cmd_o.load  = in_ready_o && in_valid_i;
    cmd_o.exec  = exec;
    out_valid_d = exec ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/smpq_dp.sv =====
// ----------------------------------------------------------------------------
// smpq_dp
// Sorted slot chain: every cell compares against the new priority at once
// and either holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module smpq_dp (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  smpq_pkg::cmd_t          cmd_i,
  input  wire logic               kind_i,
  input  smpq_pkg::priority_t     priority_req_i,
  input  smpq_pkg::payload_t      payload_i,
  output smpq_pkg::payload_t      out_payload_o,
  output logic [smpq_pkg::STATUS_W-1:0] status_o,
  output smpq_pkg::priority_t     head_priority_o,
  output smpq_pkg::payload_t      head_payload_o,
  output smpq_pkg::count_t        entry_count_o
);
  import smpq_pkg::*;

  // captured operation
  logic      kind_q;
  priority_t req_pri_q;
  payload_t  req_pay_q;

  // slot cells, index 0 is the head
  priority_t slot_pri_q [CAPACITY];
  payload_t  slot_pay_q [CAPACITY];
  priority_t slot_pri_d [CAPACITY];
  payload_t  slot_pay_d [CAPACITY];
  count_t    count_q, count_d;

  // result register
  payload_t  res_pay_q;
  status_e   res_st_q;
  priority_t res_hpri_q;
  payload_t  res_hpay_q;

  logic [CAPACITY-1:0] le;
  logic                is_enq, enq_ok, deq_ok;
  status_e             st;

  assign is_enq = (kind_q == KIND_ENQ);
  assign enq_ok = is_enq && (count_q != count_t'(CAPACITY));
  assign deq_ok = !is_enq && (count_q != '0);

  // le is a prefix mask: occupied slots at or below the new priority
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      le[i] = (count_t'(i) < count_q) &&
              ($signed(slot_pri_q[i]) <= $signed(req_pri_q));
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic      take_new;
    priority_t up_pri, dn_pri;
    payload_t  up_pay, dn_pay;

    if (g == 0) begin : g_head
      assign take_new = 1'b1;
      assign up_pri   = slot_pri_q[g];
      assign up_pay   = slot_pay_q[g];
    end else begin : g_body
      assign take_new = le[g-1];
      assign up_pri   = slot_pri_q[g-1];
      assign up_pay   = slot_pay_q[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign dn_pri = slot_pri_q[g];
      assign dn_pay = slot_pay_q[g];
    end else begin : g_mid
      assign dn_pri = slot_pri_q[g+1];
      assign dn_pay = slot_pay_q[g+1];
    end

    always_comb begin
      slot_pri_d[g] = slot_pri_q[g];
      slot_pay_d[g] = slot_pay_q[g];
      if (enq_ok && !le[g]) begin
        slot_pri_d[g] = take_new ? req_pri_q : up_pri;
        slot_pay_d[g] = take_new ? req_pay_q : up_pay;
      end else if (deq_ok) begin
        slot_pri_d[g] = dn_pri;
        slot_pay_d[g] = dn_pay;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (enq_ok)      count_d = count_q + count_t'(1);
    else if (deq_ok) count_d = count_q - count_t'(1);
  end

  always_comb begin
    st = ST_DONE;
    if (is_enq && !enq_ok)      st = ST_FULL;
    else if (!is_enq && !deq_ok) st = ST_EMPTY;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q    <= kind_i;
      req_pri_q <= priority_req_i;
      req_pay_q <= payload_i;
    end
    if (cmd_i.exec) begin
      for (int i = 0; i < CAPACITY; i++) begin
        slot_pri_q[i] <= slot_pri_d[i];
        slot_pay_q[i] <= slot_pay_d[i];
      end
      res_pay_q  <= deq_ok ? slot_pay_q[0] : '0;
      res_st_q   <= st;
      res_hpri_q <= (count_d != '0) ? slot_pri_d[0] : '0;
      res_hpay_q <= (count_d != '0) ? slot_pay_d[0] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.exec) begin
      count_q <= count_d;
    end
  end

  assign out_payload_o   = res_pay_q;
  assign status_o        = res_st_q;
  assign head_priority_o = res_hpri_q;
  assign head_payload_o  = res_hpay_q;
  assign entry_count_o   = count_q;

endmodule

`default_nettype wire

// ===== rtl/stable_min_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// stable_min_priority_queue_top
// Fixed-capacity priority queue, lowest priority first, ties in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one operation per transfer: kind 0 enqueues
//         (priority_req, payload), kind 1 dequeues the head.
//   out_o returns exactly one result per operation: removed payload, status
//         (done / dequeue on empty / enqueue rejected full), the head entry
//         after the operation and the entry count.
//   Sequencing: the sequencer takes an operation on the input transfer and
//   applies it in the EXEC state once the result register is free, loading
//   the result register; no new operation is taken meanwhile. All 16 slot
//   cells update in parallel, so the whole chain compares and shifts at once.
//   Stall: the result register holds while out_o.ready is low; one more
//   operation is taken meanwhile and waits until the result is transferred.
//   Reset: entry count goes to zero and no result is pending; slot
//   contents are not cleared and are only read once written.
// ----------------------------------------------------------------------------
`default_nettype none

module stable_min_priority_queue_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  smpq_in_if.sink     in_i,
  smpq_out_if.source  out_o
);
  import smpq_pkg::*;

  cmd_t cmd;

  smpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  smpq_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .kind_i          (in_i.kind),
    .priority_req_i  (in_i.priority_req),
    .payload_i       (in_i.payload),
    .out_payload_o   (out_o.out_payload),
    .status_o        (out_o.status),
    .head_priority_o (out_o.head_priority),
    .head_payload_o  (out_o.head_payload),
    .entry_count_o   (out_o.entry_count)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.entry_count <= count_t'(CAPACITY))
    else $error("entry count above capacity");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_FULL |-> out_o.entry_count == count_t'(CAPACITY))
    else $error("full status with free slots");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.status == ST_EMPTY |->
      out_o.entry_count == '0 && out_o.head_payload == '0 && out_o.out_payload == '0)
    else $error("empty status with data");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.valid && in_i.ready |=> !in_i.ready)
    else $error("second operation taken while one is in flight");
`endif

endmodule

`default_nettype wire
